FILE: design/sine_square_pulse_generator_macros.svh
// Assertion macros shared by the sine/square/pulse generator RTL
`ifndef SINE_SQUARE_PULSE_GENERATOR_MACROS_SVH
`define SINE_SQUARE_PULSE_GENERATOR_MACROS_SVH

// Check an implication or plain property on every clock outside reset
`define SSPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset
`define SSPG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/sspg_pkg.sv
// Types, codes and constants of the sine/square/pulse generator
package sspg_pkg;

  localparam int DEF_SINE_ADDR_BITS = 10;
  localparam int DEF_TIME_BITS      = 32;
  localparam int CMD_DEPTH          = 2;
  localparam int RES_DEPTH          = 2;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_MODE   = 2'd1,
    FUNC_FSCALE = 2'd2,
    FUNC_ASCALE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_SINE   = 2'd1,
    MODE_SQUARE = 2'd2,
    MODE_PULSE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_SET,
    ACT_TOGGLE,
    ACT_KEEP
  } mode_act_t;

  localparam logic [2:0] REQ_TOGGLE = 3'd4;

  localparam logic [2:0] CFG_FREQ_MIN   = 3'd0;
  localparam logic [2:0] CFG_FREQ_MAX   = 3'd1;
  localparam logic [2:0] CFG_AMP_MIN    = 3'd2;
  localparam logic [2:0] CFG_AMP_MAX    = 3'd3;
  localparam logic [2:0] CFG_START_FREQ = 3'd4;
  localparam logic [2:0] CFG_START_AMP  = 3'd5;

  localparam logic [31:0] RST_FREQ_MIN   = 32'd0;
  localparam logic [31:0] RST_FREQ_MAX   = 32'hFFFF_FFFF;
  localparam logic [14:0] RST_AMP_MIN    = 15'd0;
  localparam logic [14:0] RST_AMP_MAX    = 15'd32767;
  localparam logic [31:0] RST_START_FREQ = 32'd42949673;
  localparam logic [14:0] RST_START_AMP  = 15'd16384;

  localparam logic [31:0] Q15_MAX   = 32'd32767;
  localparam logic [63:0] Q30_HALF  = 64'h0000_0000_2000_0000;
  localparam logic [30:0] RND_HALF  = 31'd16384;
  localparam logic [2:0]  POLY_TOP  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  mode_request;
    logic [15:0] factor;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
    logic [1:0]         mode_now;
    logic               limit_hit;
  } out_word_t;

  typedef struct packed {
    func_t       func;
    mode_act_t   act;
    mode_t       mode_set;
    logic [15:0] factor;
  } cmd_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  // Q30 coefficients of the quarter-wave sine polynomial
  function automatic logic [31:0] poly_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = 32'd1686629713;
      3'd1:    c = 32'd693598564;
      3'd2:    c = 32'd85569278;
      3'd3:    c = 32'd5026937;
      3'd4:    c = 32'd172272;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: design/sspg_fifo.sv
// Small register queue used for commands and results
module sspg_fifo import sspg_pkg::*; #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  T     din,
  input  logic pop,
  output logic empty,
  output T     dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

FILE: design/sspg_front.sv
// Front end: accept input words, decode them into commands, queue them
module sspg_front import sspg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_word_t in_word,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  cmd_t cmd;
  logic q_empty;

  always_comb begin
    cmd.func     = func_t'(in_word.func);
    cmd.factor   = in_word.factor;
    cmd.mode_set = mode_t'(in_word.mode_request[1:0]);
    if (!in_word.mode_request[2]) begin
      cmd.act = ACT_SET;
    end else if (in_word.mode_request == REQ_TOGGLE) begin
      cmd.act = ACT_TOGGLE;
    end else begin
      cmd.act = ACT_KEEP;
    end
  end

  sspg_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .din   (cmd),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_cmd)
  );

  assign q_valid = !q_empty;

endmodule

FILE: design/sspg_back.sv
// Back end: generator state, shared multiplier and command sequencer
`include "sine_square_pulse_generator_macros.svh"

module sspg_back import sspg_pkg::*; #(
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int TIME_BITS      = DEF_TIME_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      res_push,
  output out_word_t res_word,
  input  logic      res_full
);

  localparam int QB = SINE_ADDR_BITS - 2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MODE,
    ST_TLO, ST_THI, ST_XX, ST_X2, ST_POLY, ST_SIN, ST_ROUND, ST_TFIN,
    ST_FMUL, ST_FCHK, ST_FLO, ST_FMID, ST_FHI,
    ST_AMUL, ST_ACHK,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [39:0]          offset_r, offset_nxt;
  logic [31:0]          freq_r, freq_nxt;
  logic [14:0]          amp_r, amp_nxt;
  mode_t                mode_r, mode_nxt;
  logic [31:0]          freq_min_r, freq_max_r;
  logic [14:0]          amp_min_r, amp_max_r;
  out_word_t            res_r, res_nxt;

  cmd_t                 cmd_r;
  logic [63:0]          prod_r;
  logic [31:0]          frac_r, lowhi_r;
  logic                 carry_r;
  logic                 pend_r;
  logic [30:0]          x_r, x2_r;
  logic [1:0]           quad_r;
  logic [31:0]          nf_r;
  logic [39:0]          d_r, acc_r;

  logic [31:0]          mul_a, mul_b;
  logic [63:0]          t64;
  logic                 cfg_we;

  logic [32:0]          fsum;
  logic [63:0]          pint;
  logic signed [65:0]   ip;
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [QB-1:0]        rq;
  logic [QB:0]          r;
  logic [30:0]          x;
  logic [63:0]          psh;
  logic [31:0]          tval;
  logic [63:0]          vsum;
  logic [14:0]          v;
  logic [29:0]          mag;
  logic [30:0]          rsum;
  logic signed [15:0]   rr;
  logic                 nz, neg;
  logic signed [15:0]   amp_s;
  logic signed [15:0]   samp;
  mode_t                tick_mode;
  logic [39:0]          nf;
  logic                 f_ok;
  logic [22:0]          na;
  logic                 a_ok;

  assign cfg_we = cfg.we;
  assign t64    = 64'(time_r);

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    fsum  = 33'(prod_r[31:0]) + 33'(offset_r[31:0]);
    pint  = 64'(lowhi_r) + prod_r;
    ip    = $signed({2'b00, pint}) + $signed({{58{offset_r[39]}}, offset_r[39:32]})
            + $signed({65'd0, carry_r});
    idx   = frac_r[31 -: SINE_ADDR_BITS];
    rq    = idx[QB-1:0];
    r     = idx[QB] ? (((QB + 1)'(1) << QB) - {1'b0, rq}) : {1'b0, rq};
    x     = {r, {(30 - QB){1'b0}}};
    psh   = prod_r >> 30;
    tval  = poly_coef({1'b0, k_r}) - psh[31:0];
    vsum  = prod_r + Q30_HALF;
    v     = (vsum[63:30] > 34'(Q15_MAX)) ? Q15_MAX[14:0] : vsum[44:30];
    mag   = prod_r[29:0];
    rsum  = 31'(mag) + RND_HALF;
    rr    = $signed(rsum[30:15]);
    nz    = (mag != '0);
    neg   = quad_r[1] && nz;
    amp_s = $signed({1'b0, amp_r});
    nf    = prod_r[47:8];
    f_ok  = (nf < {8'd0, freq_max_r}) && (nf > {8'd0, freq_min_r});
    na    = prod_r[30:8];
    a_ok  = (na < {8'd0, amp_max_r}) && (na > {8'd0, amp_min_r});
    tick_mode = (mode_r == MODE_PULSE && pend_r) ? MODE_OFF : mode_r;
    if (tick_mode == MODE_SQUARE) begin
      samp = (!neg && nz) ? amp_s : -amp_s;
    end else begin
      samp = neg ? -rr : rr;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    time_nxt   = time_r;
    offset_nxt = offset_r;
    freq_nxt   = freq_r;
    amp_nxt    = amp_r;
    mode_nxt   = mode_r;
    res_nxt    = res_r;
    q_pop      = 1'b0;
    res_push   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.func)
            FUNC_TICK:   state_nxt = ST_TLO;
            FUNC_MODE:   state_nxt = ST_MODE;
            FUNC_FSCALE: state_nxt = ST_FMUL;
            FUNC_ASCALE: state_nxt = ST_AMUL;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MODE: begin
        time_nxt   = '0;
        offset_nxt = '0;
        case (cmd_r.act)
          ACT_SET:    mode_nxt = cmd_r.mode_set;
          ACT_TOGGLE: mode_nxt = (mode_r == MODE_OFF) ? MODE_SINE : MODE_OFF;
          default:    mode_nxt = mode_r;
        endcase
        res_nxt.sample    = '0;
        res_nxt.active    = (mode_nxt != MODE_OFF);
        res_nxt.mode_now  = mode_nxt;
        res_nxt.limit_hit = 1'b0;
        state_nxt         = ST_DONE;
      end
      ST_TLO: begin
        mul_a     = freq_r;
        mul_b     = t64[31:0];
        state_nxt = ST_THI;
      end
      ST_THI: begin
        mul_a     = freq_r;
        mul_b     = t64[63:32];
        state_nxt = ST_XX;
      end
      ST_XX: begin
        mul_a     = 32'(x);
        mul_b     = 32'(x);
        state_nxt = ST_X2;
      end
      ST_X2: begin
        mul_a     = 32'(prod_r[60:30]);
        mul_b     = poly_coef(POLY_TOP);
        k_nxt     = 2'd3;
        state_nxt = ST_POLY;
      end
      ST_POLY: begin
        mul_b = tval;
        if (k_r != 2'd0) begin
          mul_a = 32'(x2_r);
          k_nxt = k_r - 2'd1;
        end else begin
          mul_a     = 32'(x_r);
          state_nxt = ST_SIN;
        end
      end
      ST_SIN: begin
        mul_a     = prod_r[61:30];
        mul_b     = Q15_MAX;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        mul_a     = 32'(amp_r);
        mul_b     = 32'(v);
        state_nxt = ST_TFIN;
      end
      ST_TFIN: begin
        mode_nxt          = tick_mode;
        time_nxt          = time_r + 1'b1;
        res_nxt.sample    = samp;
        res_nxt.active    = (tick_mode != MODE_OFF);
        res_nxt.mode_now  = tick_mode;
        res_nxt.limit_hit = 1'b0;
        state_nxt         = ST_DONE;
      end
      ST_FMUL: begin
        mul_a     = freq_r;
        mul_b     = 32'(cmd_r.factor);
        state_nxt = ST_FCHK;
      end
      ST_FCHK: begin
        mul_a = freq_r - nf[31:0];
        mul_b = t64[31:0];
        if (f_ok) begin
          state_nxt = ST_FLO;
        end else begin
          res_nxt.sample    = '0;
          res_nxt.active    = (mode_r != MODE_OFF);
          res_nxt.mode_now  = mode_r;
          res_nxt.limit_hit = 1'b1;
          state_nxt         = ST_DONE;
        end
      end
      ST_FLO: begin
        mul_a     = 32'(d_r[39:32]);
        mul_b     = 32'(t64[7:0]);
        state_nxt = ST_FMID;
      end
      ST_FMID: begin
        mul_a     = 32'(d_r[7:0]);
        mul_b     = 32'(t64[39:32]);
        state_nxt = ST_FHI;
      end
      ST_FHI: begin
        offset_nxt        = offset_r + acc_r + {prod_r[7:0], 32'd0};
        freq_nxt          = nf_r;
        res_nxt.sample    = '0;
        res_nxt.active    = (mode_r != MODE_OFF);
        res_nxt.mode_now  = mode_r;
        res_nxt.limit_hit = 1'b0;
        state_nxt         = ST_DONE;
      end
      ST_AMUL: begin
        mul_a     = 32'(amp_r);
        mul_b     = 32'(cmd_r.factor);
        state_nxt = ST_ACHK;
      end
      ST_ACHK: begin
        if (a_ok) begin
          amp_nxt = na[14:0];
        end
        res_nxt.sample    = '0;
        res_nxt.active    = (mode_r != MODE_OFF);
        res_nxt.mode_now  = mode_r;
        res_nxt.limit_hit = !a_ok;
        state_nxt         = ST_DONE;
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && cfg.index == CFG_START_FREQ) begin
      freq_nxt = cfg.data;
    end
    if (cfg_we && cfg.index == CFG_START_AMP) begin
      amp_nxt = cfg.data[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      k_r        <= '0;
      time_r     <= '0;
      offset_r   <= '0;
      freq_r     <= RST_START_FREQ;
      amp_r      <= RST_START_AMP;
      mode_r     <= MODE_OFF;
      freq_min_r <= RST_FREQ_MIN;
      freq_max_r <= RST_FREQ_MAX;
      amp_min_r  <= RST_AMP_MIN;
      amp_max_r  <= RST_AMP_MAX;
      res_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      time_r   <= time_nxt;
      offset_r <= offset_nxt;
      freq_r   <= freq_nxt;
      amp_r    <= amp_nxt;
      mode_r   <= mode_nxt;
      res_r    <= res_nxt;
      if (cfg_we) begin
        case (cfg.index)
          CFG_FREQ_MIN: freq_min_r <= cfg.data;
          CFG_FREQ_MAX: freq_max_r <= cfg.data;
          CFG_AMP_MIN:  amp_min_r  <= cfg.data[14:0];
          CFG_AMP_MAX:  amp_max_r  <= cfg.data[14:0];
          default:      freq_min_r <= freq_min_r;
        endcase
      end
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == ST_THI) begin
      frac_r  <= fsum[31:0];
      carry_r <= fsum[32];
      lowhi_r <= prod_r[63:32];
    end
    if (state_r == ST_XX) begin
      pend_r <= (ip > 66'sd1) || ((ip == 66'sd1) && (frac_r != '0));
      x_r    <= x;
      quad_r <= idx[SINE_ADDR_BITS-1 -: 2];
    end
    if (state_r == ST_X2) begin
      x2_r <= prod_r[60:30];
    end
    if (state_r == ST_FCHK) begin
      nf_r <= nf[31:0];
      d_r  <= {8'd0, freq_r} - nf;
    end
    if (state_r == ST_FLO) begin
      acc_r <= prod_r[39:0];
    end
    if (state_r == ST_FMID) begin
      acc_r <= acc_r + {prod_r[7:0], 32'd0};
    end
  end

  assign res_word = res_r;

  `SSPG_ASSERT(a_active_matches_mode, clk, rst_n, res_push |-> (res_r.active == (res_r.mode_now != MODE_OFF)), "active flag disagrees with reported mode")
  `SSPG_ASSERT(a_hit_only_on_scale, clk, rst_n, (res_push && res_r.limit_hit) |-> (cmd_r.func == FUNC_FSCALE || cmd_r.func == FUNC_ASCALE), "limit hit on a non-scaling word")
  `SSPG_ASSERT(a_freq_hold, clk, rst_n, (state_r != ST_FHI && !cfg_we) |=> $stable(freq_r), "frequency changed outside scaling or config write")
  `SSPG_ASSERT(a_tick_advance, clk, rst_n, (state_r == ST_TFIN) |=> (time_r == TIME_BITS'($past(time_r) + 1'b1)), "tick did not advance time by one")

endmodule

FILE: design/sine_square_pulse_generator.sv
// Tick: an accepted word runs a chain of dependent products through the single shared
// 32x32 multiplier; the sequencer pops no new command until the result is pushed.
// Mode change needs no product; a refused frequency scaling skips the offset products.
// Command and result queues hold two words each, so input is taken while a result waits.
// Reset is synchronous on rst_n low: queues empty, limits and start values to defaults,
// frequency and amplitude loaded from the start values, time and offset zero, mode off.
module sine_square_pulse_generator import sspg_pkg::*; #(
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int TIME_BITS      = DEF_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_word_t    in_word,
  input  logic        out_pop,
  output logic        out_empty,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic      q_valid, q_pop;
  cmd_t      q_cmd;
  logic      res_push, res_full;
  out_word_t res_word;
  cfg_wr_t   cfg;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sspg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  sspg_back #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .TIME_BITS      (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .res_push (res_push),
    .res_word (res_word),
    .res_full (res_full)
  );

  sspg_fifo #(.T(out_word_t), .DEPTH(RES_DEPTH)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_word),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_word)
  );

endmodule

FILE: tb/sine_square_pulse_generator_tb.sv
// Self-checking testbench for the sine/square/pulse generator: scoreboard, drivers, phases
`timescale 1ns / 100ps

module sine_square_pulse_generator_tb;
  import sspg_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int          MAX_REPORTS  = 200;
  localparam int          IN_BITS      = $bits(in_word_t);
  localparam logic [2:0]  CFG_UNUSED   = 3'd6;
  localparam logic [2:0]  REQ_SPARE_LO = 3'd5;
  localparam logic [2:0]  REQ_SPARE_HI = 3'd7;

  localparam longint unsigned C0 = 64'd1686629713;
  localparam longint unsigned C1 = 64'd693598564;
  localparam longint unsigned C2 = 64'd85569278;
  localparam longint unsigned C3 = 64'd5026937;
  localparam longint unsigned C4 = 64'd172272;

  typedef enum {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_PERIODIC} pop_style_t;

  class waveform_scoreboard;
    out_word_t   expected_words[$];
    int          errors;
    logic [31:0] freq_min, freq_max, start_freq, freq, time_cnt;
    logic [14:0] amp_min, amp_max, start_amp, amp;
    logic [39:0] offset;
    mode_t       mode;

    function new();
      errors     = 0;
      freq_min   = RST_FREQ_MIN;
      freq_max   = RST_FREQ_MAX;
      amp_min    = RST_AMP_MIN;
      amp_max    = RST_AMP_MAX;
      start_freq = RST_START_FREQ;
      start_amp  = RST_START_AMP;
      freq       = RST_START_FREQ;
      amp        = RST_START_AMP;
      time_cnt   = '0;
      offset     = '0;
      mode       = MODE_OFF;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_FREQ_MIN: freq_min = data;
        CFG_FREQ_MAX: freq_max = data;
        CFG_AMP_MIN: amp_min = data[14:0];
        CFG_AMP_MAX: amp_max = data[14:0];
        CFG_START_FREQ: begin
          start_freq = data;
          freq = data;
        end
        CFG_START_AMP: begin
          start_amp = data[14:0];
          amp = data[14:0];
        end
        default: ;
      endcase
    endfunction

    function int sine_value(logic [9:0] idx);
      longint unsigned r, x, x2, t, s, v;
      r = idx[7:0];
      if (idx[8]) r = 64'd256 - r;
      x  = r << 22;
      x2 = (x * x) >> 30;
      t  = C4;
      t  = C3 - ((x2 * t) >> 30);
      t  = C2 - ((x2 * t) >> 30);
      t  = C1 - ((x2 * t) >> 30);
      t  = C0 - ((x2 * t) >> 30);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return idx[9] ? -int'(v) : int'(v);
    endfunction

    function out_word_t generator_output(in_word_t w);
      out_word_t       res;
      longint unsigned low, sum, nf, d;
      longint          ip;
      logic [31:0]     frac, na;
      int              prod, mag, rr, smp;
      smp = 0;
      res.limit_hit = 1'b0;
      case (func_t'(w.func))
        FUNC_TICK: begin
          low  = 64'(freq) * 64'(time_cnt);
          sum  = 64'(low[31:0]) + 64'(offset[31:0]);
          frac = sum[31:0];
          ip   = longint'(low >> 32) + longint'($signed(offset[39:32])) + longint'(sum >> 32);
          prod = int'(amp) * sine_value(frac[31:22]);
          mag  = (prod < 0) ? -prod : prod;
          rr   = (mag + 16384) >> 15;
          smp  = (prod < 0) ? -rr : rr;
          if (mode == MODE_PULSE && (ip > 1 || (ip == 1 && frac != 0))) mode = MODE_OFF;
          if (mode == MODE_SQUARE) smp = (prod > 0) ? int'(amp) : -int'(amp);
          time_cnt = time_cnt + 1;
        end
        FUNC_MODE: begin
          time_cnt = '0;
          offset   = '0;
          if (w.mode_request < REQ_TOGGLE) mode = mode_t'(w.mode_request[1:0]);
          else if (w.mode_request == REQ_TOGGLE) mode = (mode == MODE_OFF) ? MODE_SINE : MODE_OFF;
        end
        FUNC_FSCALE: begin
          nf = (64'(freq) * 64'(w.factor)) >> 8;
          if (nf < 64'(freq_max) && nf > 64'(freq_min)) begin
            d      = 64'(freq) - nf;
            offset = 40'(64'(offset) + d * 64'(time_cnt));
            freq   = nf[31:0];
          end else begin
            res.limit_hit = 1'b1;
          end
        end
        default: begin
          na = (32'(amp) * 32'(w.factor)) >> 8;
          if (na < 32'(amp_max) && na > 32'(amp_min)) amp = na[14:0];
          else res.limit_hit = 1'b1;
        end
      endcase
      res.sample   = 16'(smp);
      res.active   = (mode != MODE_OFF);
      res.mode_now = mode;
      return res;
    endfunction

    function void note_input(in_word_t w);
      expected_words.push_back(generator_output(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected word: sample %0d active %0b mode %0d limit_hit %0b",
                   $time, got.sample, got.active, got.mode_now, got.limit_hit);
        return;
      end
      want = expected_words.pop_front();
      if (got.sample !== want.sample || got.active !== want.active ||
          got.mode_now !== want.mode_now || got.limit_hit !== want.limit_hit) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t mismatch: expected sample %0d active %0b mode %0d limit_hit %0b, got sample %0d active %0b mode %0d limit_hit %0b",
                   $time, want.sample, want.active, want.mode_now, want.limit_hit,
                   got.sample, got.active, got.mode_now, got.limit_hit);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_word_t    in_word = '0;
  logic        out_pop = 1'b0;
  logic        out_empty;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  waveform_scoreboard sb;
  int unsigned        cycle_count = 0;
  int unsigned        words_sent = 0;
  int unsigned        burst_left = 1;
  pop_style_t         pop_style = POP_ALWAYS;

  sine_square_pulse_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycle_count % 256 == 0) pop_style <= pop_style_t'($urandom_range(0, 3));
    case (pop_style)
      POP_ALWAYS: out_pop <= 1'b1;
      POP_HALF: out_pop <= 1'($urandom_range(0, 1));
      POP_SPARSE: out_pop <= ($urandom_range(0, 7) == 0);
      default: out_pop <= cycle_count[4];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_result(out_word);
  end

  function automatic in_word_t command(input func_t f, input logic [2:0] req,
                                       input logic [15:0] fac);
    in_word_t w;
    w.func         = f;
    w.mode_request = req;
    w.factor       = fac;
    return w;
  endfunction

  function automatic in_word_t random_command();
    in_word_t    w;
    int unsigned roll;
    roll           = $urandom_range(0, 99);
    w.mode_request = 3'($urandom_range(0, 7));
    w.factor       = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(192, 320));
    if (roll < 70) w.func = FUNC_TICK;
    else if (roll < 78) w.func = FUNC_MODE;
    else if (roll < 89) w.func = FUNC_FSCALE;
    else w.func = FUNC_ASCALE;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    in_word <= w;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    sb.note_input(w);
    words_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [31:0] fmin, input logic [31:0] fmax,
                               input logic [14:0] amin, input logic [14:0] amax,
                               input logic [31:0] sfreq, input logic [14:0] samp);
    drain();
    cfg_write(CFG_UNUSED, $urandom);
    cfg_write(CFG_FREQ_MIN, fmin);
    cfg_write(CFG_FREQ_MAX, fmax);
    cfg_write(CFG_AMP_MIN, 32'(amin));
    cfg_write(CFG_AMP_MAX, 32'(amax));
    cfg_write(CFG_START_FREQ, sfreq);
    cfg_write(CFG_START_AMP, 32'(samp));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target, seq_len;
    in_word_t    w;
    bit          noise;
    target = words_sent + count;
    while (words_sent < target) begin
      noise   = ($urandom_range(0, 9) == 0);
      seq_len = $urandom_range(8, 40);
      if (!noise) begin
        w              = random_command();
        w.func         = FUNC_MODE;
        w.mode_request = 3'($urandom_range(MODE_SINE, MODE_PULSE));
        send_word(w);
      end
      repeat (seq_len) begin
        if (noise) w = in_word_t'(IN_BITS'($urandom));
        else w = random_command();
        send_word(w);
      end
    end
  endtask

  initial begin
    logic [31:0] fmin;
    logic [14:0] amin, amax;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_MODE, 3'(MODE_SINE), 16'd0));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_MODE, 3'(MODE_SQUARE), 16'd0));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_MODE, REQ_TOGGLE, 16'd0));
    send_word(command(FUNC_MODE, REQ_TOGGLE, 16'd0));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_MODE, 3'(MODE_PULSE), 16'd0));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_MODE, REQ_SPARE_LO, 16'd0));
    send_word(command(FUNC_MODE, REQ_SPARE_HI, 16'd0));
    send_word(command(FUNC_FSCALE, 3'd0, 16'd0));
    send_word(command(FUNC_FSCALE, 3'd0, 16'hFFFF));
    send_word(command(FUNC_FSCALE, 3'd0, 16'd512));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));
    send_word(command(FUNC_FSCALE, 3'd0, 16'd128));
    send_word(command(FUNC_ASCALE, 3'd0, 16'd0));
    send_word(command(FUNC_ASCALE, 3'd0, 16'hFFFF));
    send_word(command(FUNC_ASCALE, 3'd0, 16'd257));
    send_word(command(FUNC_ASCALE, 3'd0, 16'd255));
    send_word(command(FUNC_MODE, 3'(MODE_OFF), 16'd0));
    send_word(command(FUNC_TICK, 3'd0, 16'd0));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_setting(RST_FREQ_MIN, RST_FREQ_MAX, RST_AMP_MIN, RST_AMP_MAX,
                         $urandom, RST_AMP_MAX);
        1: apply_setting(32'd1000, 32'h8000_0000, 15'd100, 15'd20000,
                         32'h8000_0000, 15'd300);
        2: apply_setting(32'hFFFF_FFFF, 32'd0, 15'h7FFF, 15'd0, 32'hFFFF_FFFF, 15'd0);
        3: begin
          fmin = $urandom >> 4;
          amin = 15'($urandom_range(0, 4000));
          amax = 15'($urandom_range(8000, 32767));
          apply_setting(fmin, fmin + ($urandom >> 1), amin, amax,
                        fmin + ($urandom >> 3), 15'($urandom_range(amin + 1, amax - 1)));
        end
        4: apply_setting(RST_FREQ_MIN, RST_FREQ_MAX, RST_AMP_MIN, RST_AMP_MAX,
                         32'd0, 15'd32767);
        default: apply_setting(RST_FREQ_MIN, RST_FREQ_MAX, RST_AMP_MIN, RST_AMP_MAX,
                               $urandom_range(32'h0010_0000, 32'h1000_0000),
                               15'($urandom_range(1, 32766)));
      endcase
      run_random(175);
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sine_square_pulse_generator.f
+incdir+design
design/sspg_pkg.sv
design/sspg_fifo.sv
design/sspg_front.sv
design/sspg_back.sv
design/sine_square_pulse_generator.sv
tb/sine_square_pulse_generator_tb.sv
